// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, disabled while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("port-level check failed");

// Check a property on the rising clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("port-level check failed");

`endif

// ===== rtl/core/gf2rcw_pkg.sv =====
`default_nettype none

package gf2rcw_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = 64;
  localparam int CNT_W     = 7;
  localparam int ADDR_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NUM_BYTES = ROW_W / 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + 4'(b[i]);
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gf2rcw_ram.sv =====
`default_nettype none

module gf2rcw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gf2_row_combination_weight.sv =====
// Writes may be issued back to back; they return no result.
// A query over N rows (N = saturated rows_in_use) holds busy and raises done for
// one cycle when the weight is ready, skipping the row scan when N is zero; the
// next request is taken in the done cycle. The scan reads the rows through the
// single read port of the row memory, one row per cycle.
// Synchronous reset clears control and sets both counts to 64; rows stay unwritten.
`default_nettype none

module gf2_row_combination_weight (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 req_type,
  input  wire logic [5:0]                           row_index,
  input  wire logic [63:0]                          row_bits,
  input  wire logic [63:0]                          select_mask,
  output logic                                      done,
  output logic [6:0]                                weight,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [gf2rcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [6:0]                           cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SUM_BYTES,
    ST_SUM_TOTAL
  } state_t;

  state_t state;

  logic [gf2rcw_pkg::CNT_W-1:0]  rows_in_use;
  logic [gf2rcw_pkg::CNT_W-1:0]  cols_in_use;
  logic [gf2rcw_pkg::CNT_W-1:0]  nrows;
  logic [gf2rcw_pkg::CNT_W-1:0]  rd_cnt;
  logic                          rd_vld;
  logic [63:0]                   mask;
  logic [gf2rcw_pkg::ROW_W-1:0]  acc;
  logic [gf2rcw_pkg::ROW_W-1:0]  colmask;
  logic [3:0]                    byte_cnt [gf2rcw_pkg::NUM_BYTES];

  logic [gf2rcw_pkg::CNT_W-1:0]  nrows_next;
  logic [gf2rcw_pkg::CNT_W-1:0]  ncols_sat;
  logic [gf2rcw_pkg::ROW_W-1:0]  colmask_next;
  logic [gf2rcw_pkg::ROW_W-1:0]  acc_masked;
  logic [gf2rcw_pkg::CNT_W-1:0]  weight_next;
  logic [gf2rcw_pkg::ROW_W-1:0]  rdata;
  logic                          accept;
  logic                          ram_we;
  logic                          ram_re;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign ram_we    = accept && !req_type &&
                     (7'(row_index) < 7'(gf2rcw_pkg::MAX_ROWS));
  assign ram_re    = (state == ST_SCAN);

  always_comb begin
    nrows_next = (rows_in_use > 7'(gf2rcw_pkg::MAX_ROWS)) ?
                 7'(gf2rcw_pkg::MAX_ROWS) : rows_in_use;
    ncols_sat  = (cols_in_use > 7'(gf2rcw_pkg::MAX_COLS)) ?
                 7'(gf2rcw_pkg::MAX_COLS) : cols_in_use;
    for (int c = 0; c < gf2rcw_pkg::ROW_W; c++) begin
      colmask_next[c] = (7'(c) < ncols_sat);
    end
    acc_masked = acc & colmask;
    weight_next = '0;
    for (int b = 0; b < gf2rcw_pkg::NUM_BYTES; b++) begin
      weight_next = weight_next + 7'(byte_cnt[b]);
    end
  end

  gf2rcw_ram #(
    .WIDTH(gf2rcw_pkg::ROW_W),
    .DEPTH(gf2rcw_pkg::MAX_ROWS)
  ) u_row_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(row_index[gf2rcw_pkg::ADDR_W-1:0]),
    .wdata(row_bits),
    .re   (ram_re),
    .raddr(rd_cnt[gf2rcw_pkg::ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      busy        <= 1'b0;
      done        <= 1'b0;
      rd_vld      <= 1'b0;
      rd_cnt      <= '0;
      rows_in_use <= 7'd64;
      cols_in_use <= 7'd64;
    end else begin
      done   <= (state == ST_SUM_TOTAL);
      rd_vld <= ram_re;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gf2rcw_pkg::CFG_ROWS_IN_USE: rows_in_use <= cfg_data;
          gf2rcw_pkg::CFG_COLS_IN_USE: cols_in_use <= cfg_data;
          default: ;
        endcase
      end

      // fold in the row read last cycle
      if (rd_vld) begin
        if (mask[0]) begin
          acc <= acc ^ rdata;
        end
        mask <= mask >> 1;
      end

      case (state)
        ST_IDLE: begin
          if (accept && req_type) begin
            busy    <= 1'b1;
            mask    <= select_mask;
            nrows   <= nrows_next;
            colmask <= colmask_next;
            acc     <= '0;
            rd_cnt  <= '0;
            state   <= (nrows_next == '0) ? ST_SUM_BYTES : ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_cnt <= rd_cnt + 7'd1;
          if (rd_cnt == nrows - 7'd1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_SUM_BYTES;
        end
        ST_SUM_BYTES: begin
          for (int b = 0; b < gf2rcw_pkg::NUM_BYTES; b++) begin
            byte_cnt[b] <= gf2rcw_pkg::popcount8(acc_masked[b*8 +: 8]);
          end
          state <= ST_SUM_TOTAL;
        end
        ST_SUM_TOTAL: begin
          weight <= weight_next;
          busy   <= 1'b0;
          state  <= ST_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gf2rcw_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module gf2rcw_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       req_type,
  input wire logic       done,
  input wire logic [6:0] weight
);

  `ASSERT_CLK_RST(a_query_sets_busy, clk, rst, (start && !busy && req_type) |=> busy)
  `ASSERT_CLK_RST(a_write_no_result, clk, rst, (start && !busy && !req_type) |=> (!busy && !done))
  `ASSERT_CLK_RST(a_done_one_cycle, clk, rst, done |=> !done)
  `ASSERT_CLK_RST(a_busy_ends_in_done, clk, rst, ($fell(busy) && !$past(rst)) |-> done)
  `ASSERT_CLK_RST(a_weight_range, clk, rst, done |-> (weight <= 7'(gf2rcw_pkg::MAX_COLS)))

endmodule

bind gf2_row_combination_weight gf2rcw_checker u_gf2rcw_checker (.*);

`default_nettype wire
